// ===== design/bfpa_pkg.sv =====
// Shared types and constants for the best-fit partition allocator.
`default_nettype none
package bfpa_pkg;

   localparam int unsigned PARTITIONS_DEFAULT = 16;
   localparam int unsigned SIZE_WIDTH_DEFAULT = 16;

   localparam int unsigned SIZE_IN_WIDTH   = 16;
   localparam int unsigned INDEX_IN_WIDTH  = 4;
   localparam int unsigned INDEX_OUT_WIDTH = 4;
   localparam int unsigned COUNT_WIDTH     = 5;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 5'd16;

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_ALLOCATE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== design/bfpa_if.sv =====
// Request and response channel interfaces of the best-fit partition allocator.
`default_nettype none
interface bfpa_req_if;
   logic                                         valid;
   logic                                         ready;
   bfpa_pkg::opcode_type                         opcode;
   logic [bfpa_pkg::INDEX_IN_WIDTH-1:0]          partition_index;
   logic [bfpa_pkg::SIZE_IN_WIDTH-1:0]           size_value;

   modport source (output valid, opcode, partition_index, size_value, input ready);
   modport sink   (input valid, opcode, partition_index, size_value, output ready);
endinterface

interface bfpa_rsp_if;
   logic                                         valid;
   logic                                         ready;
   logic                                         granted;
   logic [bfpa_pkg::INDEX_OUT_WIDTH-1:0]         chosen_partition;

   modport source (output valid, granted, chosen_partition, input ready);
   modport sink   (input valid, granted, chosen_partition, output ready);
endinterface
`default_nettype wire

// ===== design/bfpa_cell.sv =====
// One partition cell: holds size and free mark, updates the passing search token.
`default_nettype none
module bfpa_cell #(
   parameter int unsigned SIZE_WIDTH = 16,
   parameter int unsigned IDX_W      = 4,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bfpa_pkg::cell_ctrl_type              ctrl,
   input  logic [SIZE_WIDTH-1:0]                load_size,
   input  logic [bfpa_pkg::COUNT_WIDTH-1:0]     count,
   input  logic                                 tok_valid_i,
   input  logic [SIZE_WIDTH-1:0]                tok_req_i,
   input  logic                                 tok_found_i,
   input  logic [SIZE_WIDTH-1:0]                tok_best_size_i,
   input  logic [IDX_W-1:0]                     tok_best_idx_i,
   output logic                                 tok_valid_o,
   output logic [SIZE_WIDTH-1:0]                tok_req_o,
   output logic                                 tok_found_o,
   output logic [SIZE_WIDTH-1:0]                tok_best_size_o,
   output logic [IDX_W-1:0]                     tok_best_idx_o
);
   import bfpa_pkg::*;

   logic                  free_ff;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic                  tok_valid_ff;
   logic [SIZE_WIDTH-1:0] tok_req_ff;
   logic                  tok_found_ff;
   logic [SIZE_WIDTH-1:0] tok_best_size_ff;
   logic [IDX_W-1:0]      tok_best_idx_ff;

   logic active;
   logic hit;
   logic better;

   assign active = 32'(CELL_INDEX) < 32'(count);
   assign hit    = tok_valid_i && active && free_ff && (size_ff >= tok_req_i);
   assign better = hit && (!tok_found_i || (size_ff < tok_best_size_i));

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b0;
      end else if (ctrl.load) begin
         free_ff <= 1'b1;
      end else if (ctrl.clear) begin
         free_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         size_ff <= load_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_i;
      end
   end

   always_ff @(posedge clock) begin
      tok_req_ff       <= tok_req_i;
      tok_found_ff     <= tok_found_i || hit;
      tok_best_size_ff <= better ? size_ff : tok_best_size_i;
      tok_best_idx_ff  <= better ? IDX_W'(CELL_INDEX) : tok_best_idx_i;
   end

   assign tok_valid_o     = tok_valid_ff;
   assign tok_req_o       = tok_req_ff;
   assign tok_found_o     = tok_found_ff;
   assign tok_best_size_o = tok_best_size_ff;
   assign tok_best_idx_o  = tok_best_idx_ff;

endmodule
`default_nettype wire

// ===== design/best_fit_partition_allocator.sv =====
// Top level of the best-fit partition allocator: cell chain, control and response register.
// A load transfer writes one partition's size and marks it free.
// An allocate transfer sends a search token down a row of PARTITIONS cells, one cell
// per cycle; each cell compares its own size with the best fit so far. The token leaves
// the last cell and is captured; then, once the response register is free, the result
// is written to it while the winning cell is marked used. The response register holds a
// result until it is taken; a new item is accepted meanwhile.
// Only partitions below csr_write_data's last written count (reset 16) take part.
`default_nettype none
module best_fit_partition_allocator #(
   parameter int unsigned PARTITIONS = bfpa_pkg::PARTITIONS_DEFAULT,
   parameter int unsigned SIZE_WIDTH = bfpa_pkg::SIZE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   bfpa_req_if.sink                         req_port,
   bfpa_rsp_if.source                       rsp_port,
   input  logic                             csr_write_enable,
   input  logic [bfpa_pkg::COUNT_WIDTH-1:0] csr_write_data
);
   import bfpa_pkg::*;

   localparam int unsigned IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] count_ff;

   logic                   done_found_ff;
   logic [IDX_W-1:0]       done_idx_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_granted_ff;
   logic [INDEX_OUT_WIDTH-1:0] rsp_chosen_ff;

   logic [PARTITIONS:0]    tok_valid;
   logic [SIZE_WIDTH-1:0]  tok_req       [PARTITIONS+1];
   logic                   tok_found     [PARTITIONS+1];
   logic [SIZE_WIDTH-1:0]  tok_best_size [PARTITIONS+1];
   logic [IDX_W-1:0]       tok_best_idx  [PARTITIONS+1];

   cell_ctrl_type          ctrl [PARTITIONS];

   logic                   accept;
   logic                   load_fire;
   logic                   alloc_fire;
   logic                   capture;
   logic                   deliver;
   logic                   slot_free;
   logic [SIZE_WIDTH-1:0]  size_cut;

   assign accept     = req_port.valid && req_port.ready;
   assign load_fire  = accept && (req_port.opcode == OP_LOAD);
   assign alloc_fire = accept && (req_port.opcode == OP_ALLOCATE);
   assign slot_free  = !rsp_valid_ff || rsp_port.ready;
   assign size_cut   = SIZE_WIDTH'(req_port.size_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_port.ready = 1'b0;
      capture        = 1'b0;
      deliver        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (alloc_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_valid[PARTITIONS]) begin
               capture  = 1'b1;
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               deliver  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   assign tok_valid[0]     = alloc_fire;
   assign tok_req[0]       = size_cut;
   assign tok_found[0]     = 1'b0;
   assign tok_best_size[0] = '0;
   assign tok_best_idx[0]  = '0;

   for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
      assign ctrl[i].load  = load_fire &&
                             (32'(req_port.partition_index) == 32'(i));
      assign ctrl[i].clear = deliver && done_found_ff &&
                             (32'(done_idx_ff) == 32'(i));

      bfpa_cell #(
         .SIZE_WIDTH (SIZE_WIDTH),
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .ctrl            (ctrl[i]),
         .load_size       (size_cut),
         .count           (count_ff),
         .tok_valid_i     (tok_valid[i]),
         .tok_req_i       (tok_req[i]),
         .tok_found_i     (tok_found[i]),
         .tok_best_size_i (tok_best_size[i]),
         .tok_best_idx_i  (tok_best_idx[i]),
         .tok_valid_o     (tok_valid[i+1]),
         .tok_req_o       (tok_req[i+1]),
         .tok_found_o     (tok_found[i+1]),
         .tok_best_size_o (tok_best_size[i+1]),
         .tok_best_idx_o  (tok_best_idx[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         done_found_ff <= tok_found[PARTITIONS];
         done_idx_ff   <= tok_best_idx[PARTITIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (deliver) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_granted_ff <= done_found_ff;
         rsp_chosen_ff  <= done_found_ff ? INDEX_OUT_WIDTH'(done_idx_ff) : '0;
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.granted          = rsp_granted_ff;
   assign rsp_port.chosen_partition = rsp_chosen_ff;

   // at most one search in flight along the chain
   a_single_token : assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one search token in the cell chain");

   a_exit_in_scan : assert property (@(posedge clock) disable iff (reset)
      tok_valid[PARTITIONS] |-> state_ff == ST_SCAN)
      else $error("search token left the chain outside a scan");

   a_no_grant_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.granted) |-> rsp_port.chosen_partition == '0)
      else $error("refused allocation carries a nonzero partition");

endmodule
`default_nettype wire
